/* design/axis_argmax_argmin_reduce_assert.svh */
// Assertion macros for the argmax/argmin reduction block
`ifndef AXIS_ARGMAX_ARGMIN_REDUCE_ASSERT_SVH
`define AXIS_ARGMAX_ARGMIN_REDUCE_ASSERT_SVH

`ifndef SYNTH

`define AAMR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AAMR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AAMR_ASSERT_IMP(label, ante, cons, msg)

`define AAMR_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

/* design/aamr_pkg.sv */
// Shared types and constants for the argmax/argmin reduction block
package aamr_pkg;

    localparam int VAL_W      = 32;
    localparam int IDX_W      = 16;
    localparam int MODE_W     = 2;
    localparam int RLEN_W     = 7;
    localparam int LEN_W      = RLEN_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 1024;

    localparam logic [IDX_W-1:0]  ELEM_TOP        = 16'hFFFF;
    localparam logic [RLEN_W-1:0] ROW_LENGTH_RST  = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd2;

    // axis modes
    localparam logic [MODE_W-1:0] AXIS_WHOLE  = 2'd0;
    localparam logic [MODE_W-1:0] AXIS_COLUMN = 2'd1;
    localparam logic [MODE_W-1:0] AXIS_ROW    = 2'd2;

    typedef enum logic {
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic load;       // element belongs to this cell's column
        logic first_row;  // take element unconditionally
        logic seek_max;
        logic shift;      // take neighbor's contents
    } t_cell_ctl;

endpackage

/* design/aamr_in_if.sv */
// Element channel: one matrix element per item
interface aamr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [aamr_pkg::VAL_W-1:0]   value;
    logic                                last_element;

    modport source (output valid, output value, output last_element, input ready);
    modport sink   (input valid, input value, input last_element, output ready);
endinterface

/* design/aamr_out_if.sv */
// Result channel: one extreme value and its index per item
interface aamr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [aamr_pkg::VAL_W-1:0]   extreme_value;
    logic [aamr_pkg::IDX_W-1:0]          best_index;
    logic                                last_result;

    modport source (output valid, output extreme_value, output best_index,
                    output last_result, input ready);
    modport sink   (input valid, input extreme_value, input best_index,
                    input last_result, output ready);
endinterface

/* design/aamr_cell.sv */
// One column cell: best value and row so far, shifts toward cell 0 on readout
module aamr_cell #(
    parameter int ROW_W = 10
) (
    input  logic                              i_clk,
    input  aamr_pkg::t_cell_ctl               i_ctl,
    input  logic signed [aamr_pkg::VAL_W-1:0] i_value,
    input  logic [ROW_W-1:0]                  i_row,
    input  logic signed [aamr_pkg::VAL_W-1:0] i_next_value,
    input  logic [ROW_W-1:0]                  i_next_row,
    output logic signed [aamr_pkg::VAL_W-1:0] o_value,
    output logic [ROW_W-1:0]                  o_row
);

    logic signed [aamr_pkg::VAL_W-1:0] r_value;
    logic [ROW_W-1:0]                  r_row;
    logic                              w_beats;

    always_comb begin
        w_beats = i_ctl.seek_max ? (i_value > r_value) : (i_value < r_value);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_next_value;
            r_row   <= i_next_row;
        end else if (i_ctl.load && (i_ctl.first_row || w_beats)) begin
            r_value <= i_value;
            r_row   <= i_row;
        end
    end

    assign o_value = r_value;
    assign o_row   = r_row;

endmodule

/* design/axis_argmax_argmin_reduce.sv */
// Top level: streaming argmax/argmin over a matrix, its rows or its columns
//
//  port       dir  kind         carries
//  i_elem     in   valid/ready  value, last_element
//  o_result   out  valid/ready  extreme_value, best_index, last_result
//  i_cfg_*    in   write only   axis_mode, seek_max, row_length
//
// Whole-matrix and row modes take one element per cycle while the result
// register drains; the running best is one compare-and-select per element.
// Column mode keeps one cell per column; at the matrix end the results
// shift out through cell 0, one per column (fewer on a short first row),
// input held off meanwhile. Reset is synchronous; column cells are not cleared.
`include "axis_argmax_argmin_reduce_assert.svh"

module axis_argmax_argmin_reduce #(
    parameter int MAX_COLUMNS = aamr_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = aamr_pkg::DEF_MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    aamr_in_if.sink                             i_elem,
    aamr_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [aamr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [aamr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LEN_W = aamr_pkg::LEN_W;
    localparam int VAL_W = aamr_pkg::VAL_W;
    localparam int IDX_W = aamr_pkg::IDX_W;

    // configuration
    logic [aamr_pkg::MODE_W-1:0] r_axis_mode;
    logic                        r_seek_max;
    logic [aamr_pkg::RLEN_W-1:0] r_row_length;

    // position counters and running best
    logic [CW-1:0]               r_col_pos, n_col_pos;
    logic [RW-1:0]               r_row_pos, n_row_pos;
    logic [IDX_W-1:0]            r_elem_pos, n_elem_pos;
    logic signed [VAL_W-1:0]     r_run_val, n_run_val;
    logic [IDX_W-1:0]            r_run_idx, n_run_idx;

    aamr_pkg::t_state            r_state, n_state;
    logic [LEN_W-1:0]            r_cnt, n_cnt;

    logic                        r_out_valid;
    logic signed [VAL_W-1:0]     r_out_value;
    logic [IDX_W-1:0]            r_out_index;
    logic                        r_out_last;

    logic [LEN_W-1:0]            w_eff_len;
    logic [LEN_W-1:0]            w_col_ext;
    logic [LEN_W-1:0]            w_col_cnt;
    logic                        w_row_end;
    logic                        w_is_col;
    logic                        w_is_row;
    logic                        w_out_free;
    logic                        w_in_ready;
    logic                        w_in_acc;
    logic                        w_drain_step;
    logic                        w_beats;
    logic                        w_take;
    logic                        w_emit;
    logic                        w_emit_last;
    logic                        w_out_load;

    logic signed [VAL_W-1:0]     w_cell_val [MAX_COLUMNS];
    logic [RW-1:0]               w_cell_row [MAX_COLUMNS];

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_mode  <= aamr_pkg::AXIS_WHOLE;
            r_seek_max   <= 1'b1;
            r_row_length <= aamr_pkg::ROW_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aamr_pkg::CFG_AXIS_MODE:  r_axis_mode  <= i_cfg_data[aamr_pkg::MODE_W-1:0];
                aamr_pkg::CFG_SEEK_MAX:   r_seek_max   <= i_cfg_data[0];
                aamr_pkg::CFG_ROW_LENGTH: r_row_length <= i_cfg_data[aamr_pkg::RLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- decode ----------------
    always_comb begin
        w_is_col = 1'b0;
        w_is_row = 1'b0;
        unique case (r_axis_mode)
            aamr_pkg::AXIS_COLUMN: w_is_col = 1'b1;
            aamr_pkg::AXIS_ROW:    w_is_row = 1'b1;
            default: ;  // whole matrix, also the unused code
        endcase
    end

    always_comb begin
        if (r_row_length == '0) begin
            w_eff_len = LEN_W'(1);
        end else if ({1'b0, r_row_length} > LEN_W'(MAX_COLUMNS)) begin
            w_eff_len = LEN_W'(MAX_COLUMNS);
        end else begin
            w_eff_len = {1'b0, r_row_length};
        end
    end

    assign w_col_ext = LEN_W'(r_col_pos);
    assign w_row_end = (w_col_ext + LEN_W'(1)) >= w_eff_len;
    // short first row gives out only the columns seen so far
    assign w_col_cnt = (r_row_pos != '0) ? w_eff_len : (w_col_ext + LEN_W'(1));

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_in_ready   = (r_state == aamr_pkg::S_RUN) && w_out_free;
    assign w_in_acc     = i_elem.valid && w_in_ready;
    assign w_drain_step = (r_state == aamr_pkg::S_DRAIN) && w_out_free;

    assign i_elem.ready = w_in_ready;

    // ---------------- running best (whole and row modes) ----------------
    always_comb begin
        w_beats = r_seek_max ? (i_elem.value > r_run_val) : (i_elem.value < r_run_val);
        if (w_is_row) begin
            w_take      = (r_col_pos == '0) || w_beats;
            w_emit      = w_row_end || i_elem.last_element;
            w_emit_last = i_elem.last_element;
        end else begin
            w_take      = (r_elem_pos == '0) || w_beats;
            w_emit      = i_elem.last_element;
            w_emit_last = 1'b1;
        end
        n_run_val = r_run_val;
        n_run_idx = r_run_idx;
        if (w_in_acc && !w_is_col && w_take) begin
            n_run_val = i_elem.value;
            n_run_idx = w_is_row ? IDX_W'(r_col_pos) : r_elem_pos;
        end
    end

    // ---------------- position counters ----------------
    always_comb begin
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        n_elem_pos = r_elem_pos;
        if (w_in_acc) begin
            if (i_elem.last_element) begin
                n_col_pos  = '0;
                n_row_pos  = '0;
                n_elem_pos = '0;
            end else begin
                if (r_elem_pos < aamr_pkg::ELEM_TOP) begin
                    n_elem_pos = r_elem_pos + IDX_W'(1);
                end
                if (w_row_end) begin
                    n_col_pos = '0;
                    if (r_row_pos < RW'(MAX_ROWS - 1)) begin
                        n_row_pos = r_row_pos + RW'(1);
                    end
                end else begin
                    n_col_pos = r_col_pos + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_elem_pos <= '0;
            r_run_val  <= '0;
            r_run_idx  <= '0;
        end else begin
            r_col_pos  <= n_col_pos;
            r_row_pos  <= n_row_pos;
            r_elem_pos <= n_elem_pos;
            r_run_val  <= n_run_val;
            r_run_idx  <= n_run_idx;
        end
    end

    // ---------------- column readout sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            aamr_pkg::S_RUN: begin
                if (w_in_acc && w_is_col && i_elem.last_element) begin
                    n_state = aamr_pkg::S_DRAIN;
                    n_cnt   = w_col_cnt;
                end
            end
            aamr_pkg::S_DRAIN: begin
                if (w_drain_step) begin
                    n_cnt = r_cnt - LEN_W'(1);
                    if (r_cnt == LEN_W'(1)) begin
                        n_state = aamr_pkg::S_RUN;
                    end
                end
            end
            default: begin
                n_state = aamr_pkg::S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aamr_pkg::S_RUN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
        aamr_pkg::t_cell_ctl     w_ctl;
        logic signed [VAL_W-1:0] w_next_val;
        logic [RW-1:0]           w_next_row;

        assign w_ctl.load      = w_in_acc && w_is_col && (r_col_pos == CW'(g));
        assign w_ctl.first_row = (r_row_pos == '0);
        assign w_ctl.seek_max  = r_seek_max;
        assign w_ctl.shift     = w_drain_step;

        if (g == MAX_COLUMNS - 1) begin : g_tail
            assign w_next_val = w_cell_val[g];
            assign w_next_row = w_cell_row[g];
        end else begin : g_link
            assign w_next_val = w_cell_val[g+1];
            assign w_next_row = w_cell_row[g+1];
        end

        aamr_cell #(
            .ROW_W (RW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_value      (i_elem.value),
            .i_row        (r_row_pos),
            .i_next_value (w_next_val),
            .i_next_row   (w_next_row),
            .o_value      (w_cell_val[g]),
            .o_row        (w_cell_row[g])
        );
    end

    // ---------------- result register ----------------
    assign w_out_load = (w_in_acc && !w_is_col && w_emit) || w_drain_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain_step) begin
            r_out_value <= w_cell_val[0];
            r_out_index <= IDX_W'(w_cell_row[0]);
            r_out_last  <= (r_cnt == LEN_W'(1));
        end else if (w_out_load) begin
            r_out_value <= n_run_val;
            r_out_index <= n_run_idx;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.extreme_value = r_out_value;
    assign o_result.best_index    = r_out_index;
    assign o_result.last_result   = r_out_last;

    // ---------------- checks ----------------
    `AAMR_ASSERT_IMP(a_drain_cnt_nonzero, r_state == aamr_pkg::S_DRAIN, r_cnt != '0, "drain with zero count")
    `AAMR_ASSERT_IMP(a_no_overwrite, w_out_load, !r_out_valid || o_result.ready, "result overwritten")
    `AAMR_ASSERT_NXT(a_drain_end, w_drain_step && (r_cnt == LEN_W'(1)), (r_state == aamr_pkg::S_RUN) && o_result.valid && o_result.last_result, "readout end lost")
    `AAMR_ASSERT_NXT(a_matrix_end_clear, w_in_acc && i_elem.last_element, (r_col_pos == '0) && (r_row_pos == '0) && (r_elem_pos == '0), "counters not cleared")

endmodule
